// ===== hw/rtl/lru_pkg.sv =====
package lru_pkg;

	localparam int CAP_W   = 5;
	localparam int TOTAL_W = 16;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);

	typedef struct packed {
		logic load;
		logic hit;
		logic full;
	} lru_ctrl_t;

endpackage

// ===== hw/rtl/lru_replacement_tracker.sv =====
// access: done rises in the cycle after start, results valid while done is high
// throughput: one access per cycle, busy never asserts
// the recency stack is compared and shifted in one pass through the cell chain
// reset clears occupancy, totals and strobe; capacity resets to 16
// stack contents are not reset, only occupied cells are ever searched
// done has no back-pressure, the receiver takes each result in its cycle
module lru_replacement_tracker #(
	parameter int STACK_DEPTH = 16,
	parameter int KEY_BITS    = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [KEY_BITS-1:0]        page_key,
	input  logic                       cfg_we,
	input  logic [lru_pkg::CAP_W-1:0]  cfg_wdata,
	output logic                       done,
	output logic                       hit,
	output logic                       evict_valid,
	output logic [KEY_BITS-1:0]        evicted_key,
	output logic [lru_pkg::TOTAL_W-1:0] hit_total,
	output logic [lru_pkg::TOTAL_W-1:0] miss_total
);
	import lru_pkg::*;

	localparam int OCC_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic [CAP_W-1:0]   capacity_q;
	logic [OCC_W-1:0]   occ_q;
	logic [TOTAL_W-1:0] hits_q;
	logic [TOTAL_W-1:0] misses_q;
	logic               done_q;
	logic               hit_q;
	logic               evict_q;
	logic [KEY_BITS-1:0] evicted_q;

	logic [OCC_W-1:0]   eff_cap;
	logic               accept;
	lru_ctrl_t          ctrl;

	logic [STACK_DEPTH:0]               hit_chain;
	logic [KEY_BITS-1:0]                keys [STACK_DEPTH];
	logic [KEY_BITS-1:0]                tails [STACK_DEPTH];
	logic [KEY_BITS-1:0]                tail_or;

	assign accept = start;
	assign busy   = 1'b0;

	always_comb begin
		priority if (capacity_q == '0) begin
			eff_cap = OCC_W'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(STACK_DEPTH)) begin
			eff_cap = OCC_W'(STACK_DEPTH);
		end else begin
			eff_cap = OCC_W'(capacity_q);
		end
	end

	assign hit_chain[0] = 1'b0;
	assign ctrl.load = accept;
	assign ctrl.hit  = hit_chain[STACK_DEPTH];
	assign ctrl.full = occ_q >= eff_cap;

	for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
		logic [KEY_BITS-1:0] prev;
		if (g == 0) begin : g_head
			assign prev = page_key;
		end else begin : g_body
			assign prev = keys[g-1];
		end
		lru_cell #(
			.IDX      (g),
			.KEY_BITS (KEY_BITS),
			.OCC_W    (OCC_W)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occ        (occ_q),
			.search_key (page_key),
			.prev_key   (prev),
			.hit_up     (hit_chain[g]),
			.hit_dn     (hit_chain[g+1]),
			.key_out    (keys[g]),
			.tail_key   (tails[g])
		);
	end

	always_comb begin
		tail_or = '0;
		for (int i = 0; i < STACK_DEPTH; i++) begin
			tail_or = tail_or | tails[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			hits_q   <= '0;
			misses_q <= '0;
			done_q   <= 1'b0;
			hit_q    <= 1'b0;
			evict_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				hit_q   <= ctrl.hit;
				evict_q <= !ctrl.hit && ctrl.full;
				if (ctrl.hit) begin
					if (hits_q != TOTAL_MAX) begin
						hits_q <= hits_q + TOTAL_W'(1);
					end
				end else begin
					if (misses_q != TOTAL_MAX) begin
						misses_q <= misses_q + TOTAL_W'(1);
					end
					if (!ctrl.full) begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			evicted_q <= (!ctrl.hit && ctrl.full) ? tail_or : '0;
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign evict_valid = evict_q;
	assign evicted_key = evicted_q;
	assign hit_total   = hits_q;
	assign miss_total  = misses_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(STACK_DEPTH))
		else $error("occupancy above stack depth");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted beat without result");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !evict_valid)
		else $error("eviction reported on a hit");

	a_totals_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hit_total != $past(hit_total)) || (miss_total != $past(miss_total))
			|| (hit_total == TOTAL_MAX) || (miss_total == TOTAL_MAX))
		else $error("totals did not advance");

	a_evict_needs_occ: assert property (@(posedge clk) disable iff (!arst_n)
		evict_valid && done |-> occ_q != '0)
		else $error("eviction from empty stack");

endmodule

// ===== hw/rtl/lru_cell.sv =====
module lru_cell #(
	parameter int IDX      = 0,
	parameter int KEY_BITS = 10,
	parameter int OCC_W    = 5
) (
	input  logic                clk,
	input  lru_pkg::lru_ctrl_t  ctrl,
	input  logic [OCC_W-1:0]    occ,
	input  logic [KEY_BITS-1:0] search_key,
	input  logic [KEY_BITS-1:0] prev_key,
	input  logic                hit_up,
	output logic                hit_dn,
	output logic [KEY_BITS-1:0] key_out,
	output logic [KEY_BITS-1:0] tail_key
);
	import lru_pkg::*;

	logic [KEY_BITS-1:0] key_q;
	logic                in_use;
	logic                at_occ;
	logic                is_tail;
	logic                match;
	logic                shift;

	assign in_use  = OCC_W'(IDX) < occ;
	assign at_occ  = OCC_W'(IDX) == occ;
	assign is_tail = (occ != '0) && (OCC_W'(IDX) == occ - OCC_W'(1));
	assign match   = in_use && (key_q == search_key);
	assign hit_dn  = hit_up | match;
	assign key_out = key_q;
	assign tail_key = is_tail ? key_q : '0;

	// hit: shift up to and including the match; miss: up to tail or first free
	always_comb begin
		if (ctrl.hit) begin
			shift = !hit_up;
		end else if (ctrl.full) begin
			shift = in_use;
		end else begin
			shift = in_use | at_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && shift) begin
			key_q <= prev_key;
		end
	end

endmodule
